FILE: sv/legacy_memory_window_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// legacy memory window decoder assertion macros
// concurrent checks sampled on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef LEGACY_MEMORY_WINDOW_DECODER_TOP_ASSERT_SVH
`define LEGACY_MEMORY_WINDOW_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define LMWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lmwd_pkg.sv
// ----------------------------------------------------------------------------
// lmwd_pkg
// shared types, constants and window tables of the memory window decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmwd_pkg;

  localparam logic [31:0] CONV_END    = 32'h0009_FFFF;
  localparam logic [31:0] SHADOW_BASE = 32'h000C_0000;
  localparam logic [31:0] FSEG_BASE   = 32'h000F_0000;
  localparam logic [31:0] FSEG_END    = 32'h000F_FFFF;
  localparam int          SEG_COUNT   = 12;
  localparam int          FSEG_BIT    = 12;
  localparam int          WR_SHIFT    = 16;

  localparam logic [31:0] WIN_A0000 = 32'h000A_0000;
  localparam logic [31:0] WIN_B0000 = 32'h000B_0000;
  localparam logic [31:0] WIN_E0000 = 32'h000E_0000;
  localparam logic [31:0] SPAN_32K  = 32'h0000_7FFF;
  localparam logic [31:0] SPAN_64K  = 32'h0000_FFFF;
  localparam logic [31:0] SPAN_128K = 32'h0001_FFFF;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHADOW_CONTROL = 2'd0,
    CFG_SMRAM_CONTROL  = 2'd1,
    CFG_RAM_SIZE_MB    = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    REGION_MISS   = 3'd0,
    REGION_CONV   = 3'd1,
    REGION_SHADOW = 3'd2,
    REGION_FSEG   = 3'd3,
    REGION_SMRAM  = 3'd4,
    REGION_EXT    = 3'd5
  } region_t;

  typedef struct packed {
    logic [31:0] shadow_control;
    logic [7:0]  smram_control;
    logic [11:0] ram_size_mb;
  } cfg_t;

  typedef struct packed {
    logic smram;
    logic conv;
    logic shadow;
    logic fseg;
    logic ext;
  } match_t;

  function automatic logic [31:0] smm_start(input logic [2:0] layout);
    logic [31:0] r;
    unique case (layout)
      3'd1, 3'd3: r = WIN_B0000;
      3'd6, 3'd7: r = WIN_A0000;
      default:    r = WIN_E0000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] smm_span(input logic [2:0] layout);
    logic [31:0] r;
    unique case (layout)
      3'd1, 3'd3, 3'd6: r = SPAN_64K;
      3'd7:             r = SPAN_128K;
      default:          r = SPAN_32K;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] smm_base(input logic [2:0] layout);
    logic [31:0] r;
    unique case (layout)
      3'd0:             r = WIN_E0000;
      3'd2, 3'd6, 3'd7: r = WIN_A0000;
      default:          r = WIN_B0000;
    endcase
    return r;
  endfunction

  // dram base minus window start, modulo 2^32
  function automatic logic [31:0] smm_delta(input logic [2:0] layout);
    return smm_base(layout) - smm_start(layout);
  endfunction

endpackage

FILE: sv/lmwd_req_if.sv
// ----------------------------------------------------------------------------
// lmwd_req_if
// host access channel: one address and a write flag per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmwd_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] host_address;
  logic        is_write;

  modport source (output valid, output host_address, output is_write, input ready);
  modport sink   (input valid, input host_address, input is_write, output ready);
endinterface

FILE: sv/lmwd_rsp_if.sv
// ----------------------------------------------------------------------------
// lmwd_rsp_if
// decode result channel: hit flag, dram offset and region per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmwd_rsp_if;
  logic        valid;
  logic        ready;
  logic        ram_hit;
  logic [31:0] ram_offset;
  logic [2:0]  region;

  modport source (output valid, output ram_hit, output ram_offset, output region,
                  input ready);
  modport sink   (input valid, input ram_hit, input ram_offset, input region,
                  output ready);
endinterface

FILE: sv/lmwd_cfg_if.sv
// ----------------------------------------------------------------------------
// lmwd_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmwd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/lmwd_pipe.sv
// ----------------------------------------------------------------------------
// lmwd_pipe
// three stage decode pipeline: range match, permission and priority, offset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "legacy_memory_window_decoder_top_assert.svh"

module lmwd_pipe
  import lmwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  lmwd_req_if.sink   req,
  lmwd_rsp_if.source rsp
);

  // stage 1: range compares
  logic        v1;
  logic [31:0] a1;
  logic        w1;
  logic [2:0]  lay1;
  match_t      m1;
  match_t      m1_next;
  logic [2:0]  lay_next;
  logic [31:0] win_start;
  logic [31:0] win_end;

  // stage 2: permission and priority
  logic        v2;
  logic [31:0] a2;
  logic [31:0] so2;
  logic        hit2;
  region_t     region2;
  logic        hit2_next;
  region_t     region2_next;
  logic [3:0]  seg;
  logic [SEG_COUNT-1:0] rd_en;
  logic [SEG_COUNT-1:0] wr_en;
  logic        seg_ok;
  logic        fseg_ok;

  // stage 3: output register
  logic        v3;
  logic        hit3;
  logic [31:0] off3;
  region_t     region3;
  logic [31:0] off3_next;

  logic rdy1;
  logic rdy2;
  logic rdy3;

  assign rdy3 = !v3 || rsp.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req.ready = rdy1;

  always_comb begin
    lay_next  = cfg.smram_control[7:5];
    win_start = smm_start(lay_next);
    win_end   = win_start + smm_span(lay_next);
    m1_next.smram  = cfg.smram_control[4] && (req.host_address >= win_start) &&
                     (req.host_address <= win_end);
    m1_next.conv   = req.host_address <= CONV_END;
    m1_next.shadow = (req.host_address >= SHADOW_BASE) && (req.host_address < FSEG_BASE);
    m1_next.fseg   = (req.host_address >= FSEG_BASE) && (req.host_address <= FSEG_END);
    m1_next.ext    = (req.host_address[31:20] != 12'd0) &&
                     (req.host_address[31:20] < cfg.ram_size_mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      a1   <= req.host_address;
      w1   <= req.is_write;
      lay1 <= lay_next;
      m1   <= m1_next;
    end
  end

  always_comb begin
    seg     = a1[17:14];
    rd_en   = cfg.shadow_control[SEG_COUNT-1:0];
    wr_en   = cfg.shadow_control[WR_SHIFT+SEG_COUNT-1:WR_SHIFT];
    seg_ok  = (seg < 4'(SEG_COUNT)) && (w1 ? wr_en[seg] : rd_en[seg]);
    fseg_ok = w1 ? cfg.shadow_control[WR_SHIFT+FSEG_BIT] : cfg.shadow_control[FSEG_BIT];
    hit2_next    = 1'b0;
    region2_next = REGION_MISS;
    priority if (m1.smram) begin
      hit2_next    = 1'b1;
      region2_next = REGION_SMRAM;
    end else if (m1.conv) begin
      hit2_next    = 1'b1;
      region2_next = REGION_CONV;
    end else if (m1.shadow) begin
      hit2_next    = seg_ok;
      region2_next = seg_ok ? REGION_SHADOW : REGION_MISS;
    end else if (m1.fseg) begin
      hit2_next    = fseg_ok;
      region2_next = fseg_ok ? REGION_FSEG : REGION_MISS;
    end else if (m1.ext) begin
      hit2_next    = 1'b1;
      region2_next = REGION_EXT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      a2      <= a1;
      so2     <= a1 + smm_delta(lay1);
      hit2    <= hit2_next;
      region2 <= region2_next;
    end
  end

  always_comb begin
    if (!hit2) begin
      off3_next = 32'd0;
    end else if (region2 == REGION_SMRAM) begin
      off3_next = so2;
    end else begin
      off3_next = a2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      hit3    <= hit2;
      off3    <= off3_next;
      region3 <= region2;
    end
  end

  assign rsp.valid      = v3;
  assign rsp.ram_hit    = hit3;
  assign rsp.ram_offset = off3;
  assign rsp.region     = region3;

  `LMWD_ASSERT_NOW(a_miss_clean, v3 && !hit3, (off3 == 32'd0) && (region3 == REGION_MISS), "miss result carries offset or region")
  `LMWD_ASSERT_NOW(a_hit_region, v3 && hit3, region3 != REGION_MISS, "hit result has miss region")
  `LMWD_ASSERT_NEXT(a_fill, req.valid && rdy1, v1, "accepted access lost at stage one")
  `LMWD_ASSERT_NEXT(a_drain, v3 && rsp.ready && !v2, !v3, "delivered result repeated")

endmodule

FILE: sv/legacy_memory_window_decoder_top.sv
// ----------------------------------------------------------------------------
// legacy_memory_window_decoder_top
// host bridge memory decode for conventional, shadow, smram and extended ram
// ----------------------------------------------------------------------------
// usage:
//   req carries one host access per transfer (host_address, is_write).
//   rsp returns one result per access, in order: ram_hit, ram_offset and
//   region (miss, conventional, c-e shadow, f shadow, smram, extended).
//   cfg writes shadow_control (index 0), smram_control (index 1) and
//   ram_size_mb (index 2); other indexes are dropped. cfg is always ready
//   and must only be written while no access is in flight.
// pipeline: each access passes the three register stages of lmwd_pipe
//   (range match, permission and priority, offset select) between req
//   transfer and rsp valid.
// throughput: one access per cycle sustained while rsp is ready.
// reset: rst is synchronous; it empties the pipeline and loads the
//   registers with shadow off, smram off and 64 mb of ram.
// stall: when rsp is not ready the result holds in the output stage and
//   each stage fills in turn; req.ready drops only once all three stages
//   hold an access, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module legacy_memory_window_decoder_top
  import lmwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lmwd_req_if.sink   req,
  lmwd_rsp_if.source rsp,
  lmwd_cfg_if.sink   cfg
);

  // configuration register file
  cfg_t regs;

  // no backpressure on register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.shadow_control <= 32'd0;
      regs.smram_control  <= 8'd0;
      regs.ram_size_mb    <= 12'd64;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SHADOW_CONTROL: regs.shadow_control <= cfg.data;
        CFG_SMRAM_CONTROL:  regs.smram_control  <= cfg.data[7:0];
        CFG_RAM_SIZE_MB:    regs.ram_size_mb    <= cfg.data[11:0];
        default: ;  // index beyond the register list, write dropped
      endcase
    end
  end

  // decode pipeline, output stage doubles as the result register
  lmwd_pipe u_pipe (
    .clk (clk),
    .rst (rst),
    .cfg (regs),
    .req (req),
    .rsp (rsp)
  );

endmodule

FILE: verif/legacy_memory_window_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// legacy_memory_window_decoder_top_tb
// checks every decode result against a predictor of the window map or a table
// entry; a short directed table walks the edges and special cases, then random
// accesses run under several register settings with idle and stall on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module legacy_memory_window_decoder_top_tb;
  import lmwd_pkg::*;

  // address map as the predictor sees it
  localparam logic [31:0] CONV_TOP     = 32'h0009_FFFF;
  localparam logic [31:0] SHADOW_LO    = 32'h000C_0000;
  localparam logic [31:0] FSEG_LO      = 32'h000F_0000;
  localparam logic [31:0] FSEG_HI      = 32'h000F_FFFF;
  localparam logic [31:0] EXT_LO       = 32'h0010_0000;
  localparam int          SEG_SHIFT    = 14;
  localparam int          FSEG_RD_BIT  = 12;
  localparam int          WR_BIT_SHIFT = 16;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 48;
  localparam int BLOCK_ITEMS  = 50;
  localparam int BLOCKS       = 4;

  typedef struct packed {
    logic        hit;
    logic [31:0] offset;
    region_t     region;
  } decode_t;

  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_index;
    logic [31:0] value;
    logic        wr;
    bit          typed;
    decode_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  lmwd_req_if req ();
  lmwd_rsp_if rsp ();
  lmwd_cfg_if cfg ();

  legacy_memory_window_decoder_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [31:0] shadow_ctl = 32'h0;
  logic [7:0]  smram_ctl  = 8'h0;
  logic [11:0] ram_mb     = 12'd64;

  decode_t     pending_decodes[$];
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  bit          holdoff_request = 1'b0;

  // smram layout: window start, length - 1 and dram base
  function automatic void smm_window(input logic [2:0] layout, output logic [31:0] start,
                                     output logic [31:0] span, output logic [31:0] base);
    case (layout)
      3'd0:    begin start = 32'hE_0000; span = 32'h0_7FFF; base = 32'hE_0000; end
      3'd1,
      3'd3:    begin start = 32'hB_0000; span = 32'h0_FFFF; base = 32'hB_0000; end
      3'd2:    begin start = 32'hE_0000; span = 32'h0_7FFF; base = 32'hA_0000; end
      3'd6:    begin start = 32'hA_0000; span = 32'h0_FFFF; base = 32'hA_0000; end
      3'd7:    begin start = 32'hA_0000; span = 32'h1_FFFF; base = 32'hA_0000; end
      default: begin start = 32'hE_0000; span = 32'h0_7FFF; base = 32'hB_0000; end
    endcase
  endfunction

  function automatic decode_t decode_access(input logic [31:0] addr, input logic wr);
    decode_t     res;
    logic [31:0] w_start, w_span, w_base;
    logic [43:0] ext_limit;
    int unsigned pbit;
    res = '{hit: 1'b0, offset: 32'h0, region: REGION_MISS};
    smm_window(smram_ctl[7:5], w_start, w_span, w_base);
    ext_limit = {12'h0, ram_mb, 20'h0};
    // an enabled smram window wins over every other region
    if (smram_ctl[4] && addr >= w_start && addr <= w_start + w_span) begin
      res = '{hit: 1'b1, offset: w_base + (addr - w_start), region: REGION_SMRAM};
    end else if (addr <= CONV_TOP) begin
      res = '{hit: 1'b1, offset: addr, region: REGION_CONV};
    end else if (addr >= SHADOW_LO && addr < FSEG_LO) begin
      pbit = (addr - SHADOW_LO) >> SEG_SHIFT;
      if (wr) pbit += WR_BIT_SHIFT;
      if (shadow_ctl[pbit]) res = '{hit: 1'b1, offset: addr, region: REGION_SHADOW};
    end else if (addr >= FSEG_LO && addr <= FSEG_HI) begin
      pbit = wr ? FSEG_RD_BIT + WR_BIT_SHIFT : FSEG_RD_BIT;
      if (shadow_ctl[pbit]) res = '{hit: 1'b1, offset: addr, region: REGION_FSEG};
    end else if (addr >= EXT_LO && {12'h0, addr} < ext_limit) begin
      res = '{hit: 1'b1, offset: addr, region: REGION_EXT};
    end
    return res;
  endfunction

  function automatic stim_row_t acc(input logic [31:0] addr, input logic wr);
    return '{kind: ROW_ACCESS, reg_index: 2'd0, value: addr, wr: wr, typed: 1'b0,
             want: '{hit: 1'b0, offset: 32'h0, region: REGION_MISS}};
  endfunction

  function automatic stim_row_t acc_exp(input logic [31:0] addr, input logic wr,
                                        input logic hit, input logic [31:0] offset,
                                        input region_t region);
    return '{kind: ROW_ACCESS, reg_index: 2'd0, value: addr, wr: wr, typed: 1'b1,
             want: '{hit: hit, offset: offset, region: region}};
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
    return '{kind: ROW_CONFIG, reg_index: idx, value: data, wr: 1'b0, typed: 1'b0,
             want: '{hit: 1'b0, offset: 32'h0, region: REGION_MISS}};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one access transfer; the expectation is queued at the accepting edge
  task automatic send_access(input logic [31:0] addr, input logic wr, input bit typed,
                             input decode_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.host_address <= addr;
    req.is_write     <= wr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_decodes.push_back(typed ? want : decode_access(addr, wr));
  endtask

  // sender pauses until every outstanding access has returned
  task automatic drain_accesses();
    req.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_SHADOW_CONTROL: shadow_ctl = data;
      CFG_SMRAM_CONTROL:  smram_ctl  = data[7:0];
      CFG_RAM_SIZE_MB:    ram_mb     = data[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random address biased toward the region edges
  function automatic logic [31:0] pick_address();
    logic [31:0] w_start, w_span, w_base;
    logic [31:0] ext_top;
    int unsigned pick;
    pick    = $urandom_range(99);
    ext_top = {ram_mb, 20'h0};
    smm_window(3'($urandom_range(7)), w_start, w_span, w_base);
    if (pick < 15) return $urandom_range(0, CONV_TOP);
    if (pick < 25) return $urandom_range(32'hA_0000, 32'hB_FFFF);
    if (pick < 45) return $urandom_range(SHADOW_LO, FSEG_LO - 1);
    if (pick < 55) return $urandom_range(FSEG_LO, FSEG_HI);
    if (pick < 65) return SHADOW_LO + ($urandom_range(12) << SEG_SHIFT) - $urandom_range(1);
    if (pick < 75) return w_start + ($urandom_range(1) ? w_span : 32'h0)
                          + $urandom_range(2) - 1;
    if (pick < 82) return ext_top + $urandom_range(15) - 8;
    if (pick < 88) return EXT_LO + $urandom_range(15) - 8;
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // run limit: a hung handshake or a lost result ends here
  // ---------------------------------------------------------------------------
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side ready: random idling plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rsp_ready_gen
    int unsigned hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        hold_left       = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each transfer against the oldest pending decode
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    decode_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("result with no access pending", {29'h0, rsp.region}, 32'h0);
      end else begin
        want = pending_decodes.pop_front();
        if (rsp.ram_hit !== want.hit)
          report_mismatch("ram_hit", {31'h0, rsp.ram_hit}, {31'h0, want.hit});
        if (rsp.ram_offset !== want.offset)
          report_mismatch("ram_offset", rsp.ram_offset, want.offset);
        if (rsp.region !== want.region)
          report_mismatch("region", {29'h0, rsp.region}, {29'h0, want.region});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed table, then random blocks in three idling phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   directed[$];
    stim_row_t   row;
    int unsigned phase_send[3];
    int unsigned phase_recv[3];
    int          ph, blk, n;
    logic [31:0] value;

    phase_send = '{29, 59, 0};
    phase_recv = '{59, 29, 0};

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.host_address <= 32'h0;
    req.is_write     <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.index        <= CFG_SHADOW_CONTROL;
    cfg.data         <= 32'h0;

    // registers at reset: no shadow, no smram, 64 mb
    directed.push_back(acc_exp(32'h0000_0000, 1'b0, 1'b1, 32'h0, REGION_CONV));
    directed.push_back(acc_exp(CONV_TOP, 1'b1, 1'b1, CONV_TOP, REGION_CONV));
    directed.push_back(acc_exp(32'h000A_0000, 1'b0, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(acc_exp(SHADOW_LO, 1'b0, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(acc_exp(FSEG_HI, 1'b1, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(acc_exp(EXT_LO, 1'b0, 1'b1, EXT_LO, REGION_EXT));
    directed.push_back(acc_exp(32'h03FF_FFFF, 1'b1, 1'b1, 32'h03FF_FFFF, REGION_EXT));
    directed.push_back(acc_exp(32'h0400_0000, 1'b0, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(acc_exp(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, REGION_MISS));
    // read enables only
    directed.push_back(cfg_row(CFG_SHADOW_CONTROL, 32'h0000_1FFF));
    directed.push_back(acc_exp(SHADOW_LO, 1'b0, 1'b1, SHADOW_LO, REGION_SHADOW));
    directed.push_back(acc_exp(32'h000E_FFFF, 1'b1, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(acc_exp(FSEG_LO, 1'b0, 1'b1, FSEG_LO, REGION_FSEG));
    directed.push_back(acc_exp(FSEG_LO, 1'b1, 1'b0, 32'h0, REGION_MISS));
    // write enables only, ignored bits set too
    directed.push_back(cfg_row(CFG_SHADOW_CONTROL, 32'hFFFF_0000));
    directed.push_back(acc_exp(32'h000E_C000, 1'b1, 1'b1, 32'h000E_C000, REGION_SHADOW));
    directed.push_back(acc_exp(FSEG_HI, 1'b1, 1'b1, FSEG_HI, REGION_FSEG));
    directed.push_back(acc(32'h000C_3FFF, 1'b0));
    // smram layout 0 overrides the shadow write enable
    directed.push_back(cfg_row(CFG_SMRAM_CONTROL, {24'h0, 3'd0, 1'b1, 4'h0}));
    directed.push_back(acc_exp(32'h000E_0000, 1'b1, 1'b1, 32'h000E_0000, REGION_SMRAM));
    directed.push_back(acc(32'h000E_8000, 1'b1));
    // widest window, low bits ignored
    directed.push_back(cfg_row(CFG_SMRAM_CONTROL, {24'h0, 3'd7, 1'b1, 4'hF}));
    directed.push_back(acc_exp(32'h000B_FFFF, 1'b0, 1'b1, 32'h000B_FFFF, REGION_SMRAM));
    directed.push_back(acc(SHADOW_LO, 1'b0));
    // layout chosen but window off: legacy hole
    directed.push_back(cfg_row(CFG_SMRAM_CONTROL, {24'h0, 3'd7, 1'b0, 4'h0}));
    directed.push_back(acc_exp(32'h000A_0000, 1'b0, 1'b0, 32'h0, REGION_MISS));
    // relocated window
    directed.push_back(cfg_row(CFG_SMRAM_CONTROL, {24'h0, 3'd2, 1'b1, 4'h0}));
    directed.push_back(acc(32'h000E_7FFF, 1'b0));
    // ram size extremes
    directed.push_back(cfg_row(CFG_RAM_SIZE_MB, 32'h0000_0FFF));
    directed.push_back(acc_exp(32'hFFEF_FFFF, 1'b0, 1'b1, 32'hFFEF_FFFF, REGION_EXT));
    directed.push_back(acc_exp(32'hFFF0_0000, 1'b1, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(cfg_row(CFG_RAM_SIZE_MB, 32'h0000_0001));
    directed.push_back(acc_exp(EXT_LO, 1'b0, 1'b0, 32'h0, REGION_MISS));
    directed.push_back(cfg_row(CFG_RAM_SIZE_MB, 32'h0000_0000));
    // a write to an unused index must leave every register alone
    directed.push_back(cfg_row(CFG_UNUSED, 32'h0000_0040));
    directed.push_back(acc_exp(EXT_LO, 1'b1, 1'b0, 32'h0, REGION_MISS));
    // upper data bits dropped: 64 mb
    directed.push_back(cfg_row(CFG_RAM_SIZE_MB, 32'hFFFF_F040));
    directed.push_back(acc(32'h03FF_FFFF, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CONFIG) begin
        drain_accesses();
        write_register(row.reg_index, row.value);
      end else begin
        send_access(row.value, row.wr, row.typed, row.want);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = phase_send[ph];
      recv_idle_pct = phase_recv[ph];
      for (blk = 0; blk < BLOCKS; blk++) begin
        // registers only change with nothing in flight
        drain_accesses();
        case ($urandom_range(3))
          0:       value = 32'h0;
          1:       value = 32'hFFFF_FFFF;
          default: value = $urandom();
        endcase
        write_register(CFG_SHADOW_CONTROL, value);
        value = $urandom();
        if ($urandom_range(3) != 0) value[4] = 1'b1;
        write_register(CFG_SMRAM_CONTROL, value);
        case ($urandom_range(5))
          0:       value = 32'd1;
          1:       value = 32'd4095;
          2:       value = 32'd64;
          3:       value = $urandom_range(1, 32);
          default: value = $urandom();
        endcase
        write_register(CFG_RAM_SIZE_MB, value);

        // result side backs up while accesses keep coming
        if (blk == 0) holdoff_request = 1'b1;

        for (n = 0; n < BLOCK_ITEMS; n++) begin
          if (n == BLOCK_ITEMS / 2) drain_accesses();
          send_access(pick_address(), 1'($urandom_range(1)), 1'b0,
                      '{hit: 1'b0, offset: 32'h0, region: REGION_MISS});
        end
      end
    end

    drain_accesses();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
